// ----- hw/rtl/bracket_match_scanner_macros.svh -----
// Assertion macros used by the checker in bms_checker.sv.
`ifndef BRACKET_MATCH_SCANNER_MACROS_SVH
`define BRACKET_MATCH_SCANNER_MACROS_SVH

// Checked only while reset is released.
`define BMS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define BMS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/bms_pkg.sv -----
`default_nettype none

package bms_pkg;

    localparam int CODE_W  = 21;
    localparam int POS_W   = 16;
    localparam int STAT_W  = 3;
    localparam int COUNT_W = 7;

    typedef logic [CODE_W-1:0] code_t;
    typedef logic [1:0] kind_t;

    localparam kind_t KIND_PAREN   = 2'd0;
    localparam kind_t KIND_BRACKET = 2'd1;
    localparam kind_t KIND_BRACE   = 2'd2;
    localparam kind_t KIND_NONE    = 2'd3;

    localparam kind_t QUOTE_SINGLE = 2'd0;
    localparam kind_t QUOTE_DOUBLE = 2'd1;
    localparam kind_t QUOTE_BACK   = 2'd2;
    localparam kind_t QUOTE_NONE   = 2'd3;

    localparam code_t CH_NUL       = 21'd0;
    localparam code_t CH_DQUOTE    = 21'd34;
    localparam code_t CH_SQUOTE    = 21'd39;
    localparam code_t CH_LPAREN    = 21'd40;
    localparam code_t CH_RPAREN    = 21'd41;
    localparam code_t CH_LBRACKET  = 21'd91;
    localparam code_t CH_BACKSLASH = 21'd92;
    localparam code_t CH_RBRACKET  = 21'd93;
    localparam code_t CH_BACKTICK  = 21'd96;
    localparam code_t CH_LBRACE    = 21'd123;
    localparam code_t CH_RBRACE    = 21'd125;
    localparam code_t CH_COMMA     = 21'd44;

    typedef logic [STAT_W-1:0] status_t;

    localparam status_t ST_MATCHED      = 3'd0;
    localparam status_t ST_NOT_BRACKET  = 3'd1;
    localparam status_t ST_UNTERMINATED = 3'd2;
    localparam status_t ST_DEPTH_OVF    = 3'd3;
    localparam status_t ST_DELIM_OVF    = 3'd4;

    typedef struct packed {
        logic                push;
        logic                pop;
        kind_t               kind;
    } stack_op_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  delimiter_count;
        logic [POS_W-1:0]    length;
        status_t             status;
        logic                done_res;
        logic                is_delimiter;
        logic [POS_W-1:0]    position;
        code_t               out_code;
    } res_t;

    function automatic kind_t open_kind(code_t c);
        kind_t k;
        k = KIND_NONE;
        if (c == CH_LPAREN) begin
            k = KIND_PAREN;
        end else if (c == CH_LBRACKET) begin
            k = KIND_BRACKET;
        end else if (c == CH_LBRACE) begin
            k = KIND_BRACE;
        end
        return k;
    endfunction

    function automatic code_t closer_char(kind_t k);
        code_t c;
        case (k)
            KIND_PAREN:   c = CH_RPAREN;
            KIND_BRACKET: c = CH_RBRACKET;
            default:      c = CH_RBRACE;
        endcase
        return c;
    endfunction

    function automatic kind_t quote_of(code_t c);
        kind_t k;
        k = QUOTE_NONE;
        if (c == CH_SQUOTE) begin
            k = QUOTE_SINGLE;
        end else if (c == CH_DQUOTE) begin
            k = QUOTE_DOUBLE;
        end else if (c == CH_BACKTICK) begin
            k = QUOTE_BACK;
        end
        return k;
    endfunction

    function automatic code_t quote_char(kind_t k);
        code_t c;
        case (k)
            QUOTE_SINGLE: c = CH_SQUOTE;
            QUOTE_DOUBLE: c = CH_DQUOTE;
            default:      c = CH_BACKTICK;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/bms_closer_stack.sv -----
`default_nettype none

module bms_closer_stack #(
    parameter int STACK_DEPTH = 16
) (
    input  wire              aclk,
    input  bms_pkg::stack_op_t op,
    output bms_pkg::kind_t   top_kind
);

    bms_pkg::kind_t entry_reg  [STACK_DEPTH];
    bms_pkg::kind_t entry_next [STACK_DEPTH];

    always_comb begin
        for (int i = 0; i < STACK_DEPTH; i++) begin
            entry_next[i] = entry_reg[i];
        end
        if (op.push) begin
            entry_next[0] = op.kind;
            for (int i = 1; i < STACK_DEPTH; i++) begin
                entry_next[i] = entry_reg[i-1];
            end
        end else if (op.pop) begin
            for (int i = 0; i < STACK_DEPTH - 1; i++) begin
                entry_next[i] = entry_reg[i+1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < STACK_DEPTH; i++) begin
            entry_reg[i] <= entry_next[i];
        end
    end

    assign top_kind = entry_reg[0];

endmodule

`default_nettype wire

// ----- hw/rtl/bms_scan_ctrl.sv -----
`default_nettype none

module bms_scan_ctrl #(
    parameter int STACK_DEPTH = 16,
    parameter int MAX_DELIMS  = 64,
    parameter int POS_BITS    = 16
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  step_en,
    input  bms_pkg::code_t       char_code,
    input  wire                  start_req,
    input  bms_pkg::code_t       delimiter_code,
    output logic                 emit,
    output bms_pkg::res_t        res
);

    localparam int TW = $clog2(STACK_DEPTH + 1);
    localparam int DW = $clog2(MAX_DELIMS + 1);

    localparam logic [TW-1:0]       TOP_FULL  = TW'(STACK_DEPTH);
    localparam logic [TW-1:0]       TOP_ONE   = TW'(1);
    localparam logic [DW-1:0]       DELIM_MAX = DW'(MAX_DELIMS);
    localparam logic [POS_BITS-1:0] POS_MAX   = '1;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_SCAN = 2'd1;
    localparam logic [1:0] MODE_LIT  = 2'd2;
    localparam logic [1:0] MODE_ESC  = 2'd3;

    logic [1:0]          mode_reg,  mode_next;
    logic [TW-1:0]       top_reg,   top_next;
    bms_pkg::kind_t      quote_reg, quote_next;
    logic [POS_BITS-1:0] char_reg,  char_next;
    logic [DW-1:0]       delim_reg, delim_next;

    bms_pkg::stack_op_t  stack_op;
    bms_pkg::kind_t      top_kind;
    bms_pkg::kind_t      in_open;
    bms_pkg::kind_t      in_quote;

    logic                fin;
    bms_pkg::status_t    fin_status;
    logic                rec;
    logic                rec_isd;
    logic [TW-1:0]       new_top;
    logic                isd;
    logic [31:0]         char_wide;
    logic [31:0]         length_wide;
    logic [10:0]         delim_wide;

    bms_closer_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk     (aclk),
        .op       (stack_op),
        .top_kind (top_kind)
    );

    assign in_open  = bms_pkg::open_kind(char_code);
    assign in_quote = bms_pkg::quote_of(char_code);

    always_comb begin
        mode_next     = mode_reg;
        top_next      = top_reg;
        quote_next    = quote_reg;
        char_next     = char_reg;
        delim_next    = delim_reg;
        stack_op.push = 1'b0;
        stack_op.pop  = 1'b0;
        stack_op.kind = in_open;
        fin           = 1'b0;
        fin_status    = bms_pkg::ST_MATCHED;
        rec           = 1'b0;
        rec_isd       = 1'b0;
        new_top       = top_reg;
        isd           = 1'b0;
        emit          = 1'b0;
        res           = '0;
        char_wide     = 32'(char_reg);
        length_wide   = '0;
        delim_wide    = '0;

        if (step_en) begin
            if (start_req) begin
                char_next  = '0;
                delim_next = '0;
                quote_next = bms_pkg::QUOTE_SINGLE;
                top_next   = '0;
                if (in_open != bms_pkg::KIND_NONE) begin
                    stack_op.push = 1'b1;
                    top_next      = TOP_ONE;
                    mode_next     = MODE_SCAN;
                end else begin
                    fin        = 1'b1;
                    fin_status = bms_pkg::ST_NOT_BRACKET;
                end
            end else begin
                unique case (mode_reg)
                    MODE_SCAN: begin
                        if (char_code == bms_pkg::CH_NUL || top_reg == '0
                                || top_reg > TOP_FULL) begin
                            fin        = 1'b1;
                            fin_status = bms_pkg::ST_UNTERMINATED;
                        end else if (char_code == bms_pkg::closer_char(top_kind)) begin
                            new_top = top_reg - TOP_ONE;
                            if (new_top == '0) begin
                                fin        = 1'b1;
                                fin_status = bms_pkg::ST_MATCHED;
                            end else begin
                                stack_op.pop = 1'b1;
                            end
                        end else if (in_open != bms_pkg::KIND_NONE) begin
                            if (top_reg >= TOP_FULL) begin
                                fin        = 1'b1;
                                fin_status = bms_pkg::ST_DEPTH_OVF;
                            end else begin
                                stack_op.push = 1'b1;
                                new_top       = top_reg + TOP_ONE;
                            end
                        end
                        if (!fin) begin
                            isd = (new_top == TOP_ONE) && (char_code == delimiter_code);
                            if (isd && delim_reg >= DELIM_MAX) begin
                                fin           = 1'b1;
                                fin_status    = bms_pkg::ST_DELIM_OVF;
                                stack_op.push = 1'b0;
                                stack_op.pop  = 1'b0;
                            end else begin
                                if (isd) begin
                                    delim_next = delim_reg + DW'(1);
                                end
                                top_next = new_top;
                                if (in_quote != bms_pkg::QUOTE_NONE) begin
                                    quote_next = in_quote;
                                    mode_next  = MODE_LIT;
                                end
                                rec     = 1'b1;
                                rec_isd = isd;
                            end
                        end
                    end
                    MODE_LIT: begin
                        if (char_code == bms_pkg::CH_NUL) begin
                            fin        = 1'b1;
                            fin_status = bms_pkg::ST_UNTERMINATED;
                        end else begin
                            if (char_code == bms_pkg::quote_char(quote_reg)) begin
                                mode_next = MODE_SCAN;
                            end else if (char_code == bms_pkg::CH_BACKSLASH) begin
                                mode_next = MODE_ESC;
                            end
                            rec = 1'b1;
                        end
                    end
                    MODE_ESC: begin
                        if (char_code == bms_pkg::CH_NUL) begin
                            fin        = 1'b1;
                            fin_status = bms_pkg::ST_UNTERMINATED;
                        end else begin
                            mode_next = MODE_LIT;
                            rec       = 1'b1;
                        end
                    end
                    MODE_IDLE: begin
                    end
                endcase
            end
        end

        if (fin) begin
            mode_next           = MODE_IDLE;
            top_next            = '0;
            length_wide         = 32'(char_next);
            delim_wide          = 11'(delim_next);
            emit                = 1'b1;
            res.done_res        = 1'b1;
            res.status          = fin_status;
            res.length          = length_wide[bms_pkg::POS_W-1:0];
            res.delimiter_count = delim_wide[bms_pkg::COUNT_W-1:0];
        end

        if (rec) begin
            emit             = 1'b1;
            res.out_code     = char_code;
            res.position     = char_wide[bms_pkg::POS_W-1:0];
            res.is_delimiter = rec_isd;
            if (char_reg < POS_MAX) begin
                char_next = char_reg + POS_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            top_reg   <= '0;
            quote_reg <= bms_pkg::QUOTE_SINGLE;
            char_reg  <= '0;
            delim_reg <= '0;
        end else begin
            mode_reg  <= mode_next;
            top_reg   <= top_next;
            quote_reg <= quote_next;
            char_reg  <= char_next;
            delim_reg <= delim_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bracket_match_scanner.sv -----
// Bracket match scanner.
// Input channel s_*: one character request per handshake. A request with
// s_tuser set opens a scan and must carry '(', '[' or '{'; otherwise a done
// result with status not_bracket comes back. Every enclosed character comes
// out on m_* with its position and a top-level delimiter flag; the matching
// closer, a zero code, or a stack or delimiter overflow ends the scan with
// one done result (m_tuser bit 1) carrying status, length and delimiter count.
// The delimiter is set through cfg_wen/cfg_wdata; the user must do so only
// while no scan is running, the block does not enforce it. A request goes from
// the input register through the scan logic to the result register. Throughput
// is one request per cycle unless the receiver stalls; the closer stack is a
// shift line whose top entry is always at hand, so no step waits on a memory
// read. Reset returns the scanner to idle and empties both pipeline registers;
// the delimiter returns to ','. When the receiver stalls, the result register
// holds and the input register fills, after which s_tready drops.
`default_nettype none

module bracket_match_scanner #(
    parameter int STACK_DEPTH = 16,
    parameter int MAX_DELIMS  = 64,
    parameter int POS_BITS    = 16
) (
    input  wire         aclk,
    input  wire         aresetn,

    input  wire  [20:0] cfg_wdata,
    input  wire         cfg_wen,

    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [23:0] s_tdata,   // [20:0] char_code, [23:21] zero
    input  wire  [0:0]  s_tuser,   // [0] start_req

    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [63:0] m_tdata,   // [20:0] out_code, [36:21] position,
                                   // [39:37] status, [55:40] length,
                                   // [62:56] delimiter_count, [63] zero
    output logic [1:0]  m_tuser    // [0] is_delimiter, [1] done_res
);

    bms_pkg::code_t delim_reg, delim_next;

    logic           in_valid_reg, in_valid_next;
    bms_pkg::code_t in_code_reg,  in_code_next;
    logic           in_start_reg, in_start_next;

    logic           out_valid_reg, out_valid_next;
    bms_pkg::res_t  out_res_reg,   out_res_next;

    logic           out_free;
    logic           advance;
    logic           s_fire;
    logic           emit;
    bms_pkg::res_t  step_res;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    bms_scan_ctrl #(
        .STACK_DEPTH (STACK_DEPTH),
        .MAX_DELIMS  (MAX_DELIMS),
        .POS_BITS    (POS_BITS)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step_en        (advance),
        .char_code      (in_code_reg),
        .start_req      (in_start_reg),
        .delimiter_code (delim_reg),
        .emit           (emit),
        .res            (step_res)
    );

    always_comb begin
        delim_next     = cfg_wen ? cfg_wdata : delim_reg;

        in_valid_next  = in_valid_reg;
        in_code_next   = in_code_reg;
        in_start_next  = in_start_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
            in_code_next  = s_tdata[20:0];
            in_start_next = s_tuser[0];
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (out_free) begin
            out_valid_next = advance && emit;
            if (advance && emit) begin
                out_res_next = step_res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_reg     <= bms_pkg::CH_COMMA;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            delim_reg     <= delim_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_code_reg  <= in_code_next;
        in_start_reg <= in_start_next;
        out_res_reg  <= out_res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0,
                       out_res_reg.delimiter_count,
                       out_res_reg.length,
                       out_res_reg.status,
                       out_res_reg.position,
                       out_res_reg.out_code};
    assign m_tuser  = {out_res_reg.done_res, out_res_reg.is_delimiter};

endmodule

`default_nettype wire

// ----- hw/rtl/bms_checker.sv -----
`default_nettype none
`include "bracket_match_scanner_macros.svh"

module bms_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [63:0] m_tdata,
    input wire [1:0]  m_tuser
);

    // A stalled result keeps its valid and its contents.
    `BMS_ASSERT(a_hold_stalled, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // Reset leaves no result pending.
    `BMS_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    // A done result carries no character, position or delimiter flag.
    `BMS_ASSERT(a_done_clean, aclk, aresetn, m_tvalid && m_tuser[1] |-> m_tdata[36:0] == 37'd0 && !m_tuser[0], "done result carries character fields")

    // A character result carries no status, length or count.
    `BMS_ASSERT(a_char_clean, aclk, aresetn, m_tvalid && !m_tuser[1] |-> m_tdata[63:37] == 27'd0, "character result carries summary fields")

endmodule

bind bracket_match_scanner bms_checker u_bms_checker (.*);

`default_nettype wire

// ----- dv/bracket_match_scanner_checker.sv -----
`timescale 1ns / 1ps

module bracket_match_scanner_checker
    import bms_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic [20:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic [1:0]  m_tuser,
    output int          mismatches,
    output int          outstanding,
    output int          results_seen,
    output int          scans_closed
);

    localparam int STACK_DEPTH = 16;
    localparam int MAX_DELIMS  = 64;

    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_OPEN,
        SCAN_QUOTED,
        SCAN_ESCAPED
    } scan_state_t;

    kind_t               closers [STACK_DEPTH];
    int                  depth;
    scan_state_t         state;
    kind_t               quote;
    logic [POS_W-1:0]    n_chars;
    logic [COUNT_W-1:0]  n_delims;
    code_t               delim_reg;
    res_t                expected_q [$];

    task automatic queue_done(input status_t st);
        res_t r;
        r = '0;
        r.done_res        = 1'b1;
        r.status          = st;
        r.length          = n_chars;
        r.delimiter_count = n_delims;
        expected_q.push_back(r);
        state = SCAN_IDLE;
        depth = 0;
    endtask

    task automatic queue_char(input code_t c, input logic isd);
        res_t r;
        r = '0;
        r.out_code     = c;
        r.position     = n_chars;
        r.is_delimiter = isd;
        expected_q.push_back(r);
        if (n_chars != '1) begin
            n_chars++;
        end
    endtask

    task automatic predict(input code_t c, input logic start);
        kind_t k;
        code_t want_close;
        logic  isd;
        k = KIND_NONE;
        case (c)
            CH_LPAREN:   k = KIND_PAREN;
            CH_LBRACKET: k = KIND_BRACKET;
            CH_LBRACE:   k = KIND_BRACE;
            default: ;
        endcase
        if (start) begin
            n_chars  = '0;
            n_delims = '0;
            quote    = QUOTE_SINGLE;
            depth    = 0;
            if (k == KIND_NONE) begin
                queue_done(ST_NOT_BRACKET);
            end else begin
                closers[0] = k;
                depth      = 1;
                state      = SCAN_OPEN;
            end
            return;
        end
        case (state)
            SCAN_OPEN: begin
                if (c == CH_NUL) begin
                    queue_done(ST_UNTERMINATED);
                    return;
                end
                case (closers[depth-1])
                    KIND_PAREN:   want_close = CH_RPAREN;
                    KIND_BRACKET: want_close = CH_RBRACKET;
                    default:      want_close = CH_RBRACE;
                endcase
                if (c == want_close) begin
                    depth--;
                    if (depth == 0) begin
                        queue_done(ST_MATCHED);
                        return;
                    end
                end else if (k != KIND_NONE) begin
                    if (depth >= STACK_DEPTH) begin
                        queue_done(ST_DEPTH_OVF);
                        return;
                    end
                    closers[depth] = k;
                    depth++;
                end
                isd = (depth == 1) && (c == delim_reg);
                if (isd) begin
                    if (n_delims >= MAX_DELIMS) begin
                        queue_done(ST_DELIM_OVF);
                        return;
                    end
                    n_delims++;
                end
                case (c)
                    CH_SQUOTE: begin
                        quote = QUOTE_SINGLE;
                        state = SCAN_QUOTED;
                    end
                    CH_DQUOTE: begin
                        quote = QUOTE_DOUBLE;
                        state = SCAN_QUOTED;
                    end
                    CH_BACKTICK: begin
                        quote = QUOTE_BACK;
                        state = SCAN_QUOTED;
                    end
                    default: ;
                endcase
                queue_char(c, isd);
            end
            SCAN_QUOTED: begin
                if (c == CH_NUL) begin
                    queue_done(ST_UNTERMINATED);
                    return;
                end
                case (quote)
                    QUOTE_SINGLE: want_close = CH_SQUOTE;
                    QUOTE_DOUBLE: want_close = CH_DQUOTE;
                    default:      want_close = CH_BACKTICK;
                endcase
                if (c == want_close) begin
                    state = SCAN_OPEN;
                end else if (c == CH_BACKSLASH) begin
                    state = SCAN_ESCAPED;
                end
                queue_char(c, 1'b0);
            end
            SCAN_ESCAPED: begin
                if (c == CH_NUL) begin
                    queue_done(ST_UNTERMINATED);
                    return;
                end
                state = SCAN_QUOTED;
                queue_char(c, 1'b0);
            end
            default: ;
        endcase
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t ns: %s mismatch: expected 0x%0h, got 0x%0h",
                     $time, name, want, got);
        end
    endtask

    task automatic check_result();
        res_t want;
        if (expected_q.size() == 0) begin
            mismatches++;
            $display("%0t ns: unexpected result: expected none, got tdata 0x%h tuser 0x%h",
                     $time, m_tdata, m_tuser);
            return;
        end
        want = expected_q.pop_front();
        compare_field("out_code", 32'(want.out_code), 32'(m_tdata[20:0]));
        compare_field("position", 32'(want.position), 32'(m_tdata[36:21]));
        compare_field("status", 32'(want.status), 32'(m_tdata[39:37]));
        compare_field("length", 32'(want.length), 32'(m_tdata[55:40]));
        compare_field("delimiter_count", 32'(want.delimiter_count),
                      32'(m_tdata[62:56]));
        compare_field("is_delimiter", 32'(want.is_delimiter), 32'(m_tuser[0]));
        compare_field("done_res", 32'(want.done_res), 32'(m_tuser[1]));
        results_seen++;
        if (want.done_res) begin
            scans_closed++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            delim_reg    = CH_COMMA;
            state        = SCAN_IDLE;
            depth        = 0;
            quote        = QUOTE_SINGLE;
            n_chars      = '0;
            n_delims     = '0;
            mismatches   = 0;
            results_seen = 0;
            scans_closed = 0;
            expected_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                check_result();
            end
            if (cfg_wen) begin
                delim_reg = cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                predict(s_tdata[20:0], s_tuser[0]);
            end
        end
        outstanding = expected_q.size();
    end

endmodule

// ----- dv/bracket_match_scanner_tb.sv -----
`timescale 1ns / 1ps

module bracket_match_scanner_tb;
    import bms_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic [20:0] cfg_wdata;
    logic        cfg_wen;
    logic        s_tvalid;
    wire         s_tready;
    logic [23:0] s_tdata;
    logic [0:0]  s_tuser;
    wire         m_tvalid;
    logic        m_tready;
    wire  [63:0] m_tdata;
    wire  [1:0]  m_tuser;

    int    mismatch_total;
    int    results_waiting;
    int    results_checked;
    int    scans_closed;
    int    requests_sent;
    int    settings_used;
    int    stall_left;
    int    items_goal;
    bit    gaps_on;
    code_t delim_now;
    code_t phase_delims [8];

    bracket_match_scanner dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wdata (cfg_wdata),
        .cfg_wen   (cfg_wen),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    bracket_match_scanner_checker result_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wen      (cfg_wen),
        .cfg_wdata    (cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .mismatches   (mismatch_total),
        .outstanding  (results_waiting),
        .results_seen (results_checked),
        .scans_closed (scans_closed)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #40_000_000;
        $display("bracket_match_scanner_tb: FAIL");
        $finish;
    end

    initial begin
        m_tready   = 1'b0;
        stall_left = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else if (gaps_on && $urandom_range(0, 9) == 0) begin
                m_tready   = 1'b0;
                stall_left = $urandom_range(0, 17);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    task automatic send_req(input code_t code, input bit start);
        @(negedge aclk);
        if (gaps_on && $urandom_range(0, 7) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {3'b000, code};
        s_tuser  = start;
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
    endtask

    task automatic set_delim(input code_t value);
        send_req(CH_NUL, 1'b0);
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (results_waiting != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        cfg_wdata = value;
        cfg_wen   = 1'b1;
        @(negedge aclk);
        cfg_wen   = 1'b0;
        delim_now = value;
        settings_used++;
    endtask

    function automatic code_t pick_letter();
        return code_t'(97 + $urandom_range(0, 25));
    endfunction

    function automatic code_t pick_any();
        code_t c;
        case ($urandom_range(0, 11))
            0:       c = CH_LPAREN;
            1:       c = CH_RPAREN;
            2:       c = CH_LBRACKET;
            3:       c = CH_RBRACKET;
            4:       c = CH_LBRACE;
            5:       c = CH_RBRACE;
            6:       c = CH_SQUOTE;
            7:       c = CH_DQUOTE;
            8:       c = CH_BACKTICK;
            9:       c = (delim_now == CH_NUL) ? pick_letter() : delim_now;
            10:      c = code_t'($urandom_range(1, 1114111));
            default: c = pick_letter();
        endcase
        return c;
    endfunction

    task automatic gen_scan();
        code_t pend [$];
        code_t c;
        code_t qclose;
        bit    quoted;
        bit    ended;
        bit    plain;
        int    shape;
        int    body;
        int    pick;
        int    delims;
        quoted = 1'b0;
        ended  = 1'b0;
        delims = 0;
        qclose = CH_SQUOTE;
        case (delim_now)
            CH_NUL, CH_SQUOTE, CH_DQUOTE, CH_BACKTICK, CH_LPAREN, CH_RPAREN,
            CH_LBRACKET, CH_RBRACKET, CH_LBRACE, CH_RBRACE: plain = 1'b0;
            default: plain = 1'b1;
        endcase
        shape = $urandom_range(0, 19);
        if (shape == 0) begin
            send_req(code_t'($urandom_range(0, 1114111)), 1'b1);
            return;
        end
        case ($urandom_range(0, 2))
            0: begin
                send_req(CH_LPAREN, 1'b1);
                pend.push_back(CH_RPAREN);
            end
            1: begin
                send_req(CH_LBRACKET, 1'b1);
                pend.push_back(CH_RBRACKET);
            end
            default: begin
                send_req(CH_LBRACE, 1'b1);
                pend.push_back(CH_RBRACE);
            end
        endcase
        body = (shape <= 2) ? 60 : (shape <= 4) ? 100 : $urandom_range(0, 24);
        for (int i = 0; i < body && !ended; i++) begin
            if (quoted) begin
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    send_req(qclose, 1'b0);
                    quoted = 1'b0;
                end else if (pick == 1) begin
                    send_req(CH_BACKSLASH, 1'b0);
                    send_req(pick_any(), 1'b0);
                end else begin
                    c = pick_any();
                    if (c == qclose) begin
                        c = pick_letter();
                    end
                    send_req(c, 1'b0);
                end
            end else begin
                pick = $urandom_range(0, 11);
                if (shape <= 2 && $urandom_range(0, 1) == 1) begin
                    pick = 0;
                end else if (shape >= 3 && shape <= 4 && $urandom_range(0, 3) != 0) begin
                    pick = 6;
                end
                case (pick)
                    0, 1: begin
                        case ($urandom_range(0, 2))
                            0: begin
                                c = CH_LPAREN;
                                qclose = CH_RPAREN;
                            end
                            1: begin
                                c = CH_LBRACKET;
                                qclose = CH_RBRACKET;
                            end
                            default: begin
                                c = CH_LBRACE;
                                qclose = CH_RBRACE;
                            end
                        endcase
                        send_req(c, 1'b0);
                        if (pend.size() >= 16) begin
                            ended = 1'b1;
                        end else begin
                            pend.push_back(qclose);
                        end
                    end
                    2, 3: begin
                        if (pend.size() > 1) begin
                            send_req(pend.pop_back(), 1'b0);
                        end else begin
                            send_req(pick_letter(), 1'b0);
                        end
                    end
                    4: begin
                        case ($urandom_range(0, 2))
                            0:       c = CH_RPAREN;
                            1:       c = CH_RBRACKET;
                            default: c = CH_RBRACE;
                        endcase
                        if (c == pend[$]) begin
                            c = (c == CH_RBRACE) ? CH_RPAREN : CH_RBRACE;
                        end
                        send_req(c, 1'b0);
                    end
                    5: begin
                        case ($urandom_range(0, 2))
                            0:       qclose = CH_SQUOTE;
                            1:       qclose = CH_DQUOTE;
                            default: qclose = CH_BACKTICK;
                        endcase
                        send_req(qclose, 1'b0);
                        quoted = 1'b1;
                    end
                    6, 7: begin
                        if (plain) begin
                            send_req(delim_now, 1'b0);
                            if (pend.size() == 1) begin
                                delims++;
                                ended = (delims > 64);
                            end
                        end else begin
                            send_req(pick_letter(), 1'b0);
                        end
                    end
                    8: send_req(CH_BACKSLASH, 1'b0);
                    default: begin
                        if ($urandom_range(0, 3) == 0) begin
                            send_req(code_t'($urandom_range(1, 1114111)), 1'b0);
                        end else begin
                            send_req(pick_letter(), 1'b0);
                        end
                    end
                endcase
            end
        end
        if (ended || shape == 7 || shape == 8) begin
            return;
        end
        if (shape == 5 || shape == 6) begin
            send_req(CH_NUL, 1'b0);
            return;
        end
        if (quoted) begin
            send_req(qclose, 1'b0);
        end
        while (pend.size() > 0) begin
            send_req(pend.pop_back(), 1'b0);
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        cfg_wen       = 1'b0;
        cfg_wdata     = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        gaps_on       = 1'b1;
        delim_now     = CH_COMMA;
        requests_sent = 0;
        settings_used = 0;
        phase_delims  = '{21'd59, CH_RPAREN, CH_DQUOTE, CH_NUL, 21'd1114111,
                          21'h0F0000, 21'd0, CH_COMMA};
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        send_req(pick_letter(), 1'b0);
        send_req(CH_NUL, 1'b1);
        send_req(21'd1114111, 1'b1);
        send_req(CH_LPAREN, 1'b1);
        send_req(pick_letter(), 1'b0);
        send_req(CH_COMMA, 1'b0);
        send_req(CH_LBRACKET, 1'b0);
        send_req(CH_COMMA, 1'b0);
        send_req(CH_RBRACKET, 1'b0);
        send_req(CH_RPAREN, 1'b0);
        send_req(CH_LBRACKET, 1'b1);
        send_req(CH_RPAREN, 1'b0);
        send_req(CH_SQUOTE, 1'b0);
        send_req(CH_RBRACKET, 1'b0);
        send_req(CH_BACKSLASH, 1'b0);
        send_req(CH_SQUOTE, 1'b0);
        send_req(CH_SQUOTE, 1'b0);
        send_req(21'd1114111, 1'b0);
        send_req(CH_RBRACKET, 1'b0);
        send_req(CH_LBRACE, 1'b1);
        send_req(CH_DQUOTE, 1'b0);
        send_req(CH_NUL, 1'b0);
        send_req(CH_LPAREN, 1'b1);
        send_req(CH_BACKTICK, 1'b0);
        send_req(CH_BACKSLASH, 1'b0);
        send_req(CH_NUL, 1'b0);
        send_req(CH_LPAREN, 1'b1);
        send_req(CH_LBRACKET, 1'b1);
        send_req(CH_RBRACE, 1'b0);
        send_req(CH_NUL, 1'b0);

        phase_delims[6] = code_t'($urandom_range(0, 1114111));
        for (int p = 0; p < 8; p++) begin
            gaps_on = (p < 7);
            set_delim(phase_delims[p]);
            items_goal = requests_sent + 85;
            while (requests_sent < items_goal) begin
                gen_scan();
            end
        end

        @(negedge aclk);
        s_tvalid = 1'b0;
        while (results_waiting != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);

        $display("Run covered %0d requests over %0d delimiter settings.",
                 requests_sent, settings_used);
        $display("Checked %0d results, %0d of them scan completions.",
                 results_checked, scans_closed);
        if (mismatch_total == 0) begin
            $display("bracket_match_scanner_tb: PASS");
        end else begin
            $display("bracket_match_scanner_tb: FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/bms_pkg.sv
hw/rtl/bms_closer_stack.sv
hw/rtl/bms_scan_ctrl.sv
hw/rtl/bracket_match_scanner.sv
hw/rtl/bms_checker.sv
dv/bracket_match_scanner_checker.sv
dv/bracket_match_scanner_tb.sv
